FILE: design/coupled_bucket_index_hash_unit_macros.svh
// Assertion macros shared by the coupled bucket index hash modules.
`ifndef COUPLED_BUCKET_INDEX_HASH_UNIT_MACROS_SVH
`define COUPLED_BUCKET_INDEX_HASH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define CBIH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define CBIH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBIH_ASSERT_IMP(label, ante, cons, msg)
`define CBIH_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: design/cbih_pkg.sv
// Package with shared constants and types of the coupled bucket index hash.
`default_nettype none
package cbih_pkg;
    localparam int TABLE_BITS = 20;
    localparam int HASH_W = 32;
    localparam int DIV_W = 21;
    localparam int ROW_W = 16;
    localparam int OUT_W = 20;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_TABLE = 2'd1;
    localparam logic [IDX_W-1:0] REG_RANGE = 2'd2;
    localparam logic [IDX_W-1:0] REG_EXTRA = 2'd3;

    localparam logic MODE_CIRCULAR = 1'b0;
    localparam logic MODE_NAIVE = 1'b1;

    localparam logic [HASH_W-1:0] ANCHOR_SEED = 32'd114514;
    localparam logic [HASH_W-1:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [HASH_W-1:0] MM_C2 = 32'h1b873593;
    localparam logic [HASH_W-1:0] MM_ADD = 32'he6546b64;
    localparam logic [HASH_W-1:0] MM_LEN = 32'd4;
    localparam logic [HASH_W-1:0] MM_F1 = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] MM_F2 = 32'hc2b2ae35;

    // Settings after clamping, as seen by the datapath.
    typedef struct packed {
        logic             mode;
        logic [DIV_W-1:0] tsize;
        logic [DIV_W-1:0] window;
        logic [DIV_W-1:0] arange;
    } cfg_t;

    function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] v, input int r);
        logic [2*HASH_W-1:0] d;
        d = {v, v} << r;
        return d[2*HASH_W-1 -: HASH_W];
    endfunction
endpackage
`default_nettype wire

FILE: design/cbih_hash.sv
// Five-stage MurmurHash3 x86_32 pipeline for one word under two seeds.
`default_nettype none
module cbih_hash (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_vld,
    input  wire logic [cbih_pkg::HASH_W-1:0]  word,
    input  wire logic [cbih_pkg::ROW_W-1:0]   seed,
    output logic                              out_vld,
    output logic [cbih_pkg::HASH_W-1:0]       hash_a,
    output logic [cbih_pkg::HASH_W-1:0]       hash_b
);
    import cbih_pkg::*;

    logic [4:0] vld_reg;
    logic [HASH_W-1:0] k1_reg, k2_reg;
    logic [ROW_W-1:0] seed1_reg, seed2_reg;
    logic [HASH_W-1:0] pa_reg, pb_reg, ma_reg, mb_reg, na_reg, nb_reg;
    logic [HASH_W-1:0] k1_next, k2_next, pa_next, pb_next, ma_next, mb_next;
    logic [HASH_W-1:0] na_next, nb_next;
    logic [HASH_W-1:0] ha, hb, xa, xb, ya, yb;

    always_comb
    begin
        k1_next = word * MM_C1;
        k2_next = rotl(k1_reg, 15) * MM_C2;
        ha = rotl(ANCHOR_SEED ^ k2_reg, 13);
        hb = rotl({{(HASH_W-ROW_W){1'b0}}, seed2_reg} ^ k2_reg, 13);
        pa_next = ((ha << 2) + ha + MM_ADD) ^ MM_LEN;
        pb_next = ((hb << 2) + hb + MM_ADD) ^ MM_LEN;
        xa = pa_reg ^ (pa_reg >> 16);
        xb = pb_reg ^ (pb_reg >> 16);
        ma_next = xa * MM_F1;
        mb_next = xb * MM_F1;
        ya = ma_reg ^ (ma_reg >> 13);
        yb = mb_reg ^ (mb_reg >> 13);
        na_next = ya * MM_F2;
        nb_next = yb * MM_F2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg <= k1_next;
            seed1_reg <= seed;
            k2_reg <= k2_next;
            seed2_reg <= seed1_reg;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            ma_reg <= ma_next;
            mb_reg <= mb_next;
            na_reg <= na_next;
            nb_reg <= nb_next;
        end
    end

    assign out_vld = vld_reg[4];
    assign hash_a = na_reg ^ (na_reg >> 16);
    assign hash_b = nb_reg ^ (nb_reg >> 16);
endmodule
`default_nettype wire

FILE: design/cbih_mod_pipe.sv
// Restoring remainder pipeline, one dividend bit per stage.
`default_nettype none
`include "coupled_bucket_index_hash_unit_macros.svh"
module cbih_mod_pipe (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [cbih_pkg::HASH_W-1:0] dividend,
    input  wire logic [cbih_pkg::DIV_W-1:0]  divisor,
    output logic                             out_vld,
    output logic [cbih_pkg::DIV_W-1:0]       rem
);
    import cbih_pkg::*;

    logic [HASH_W-1:0] vld_reg;
    logic [DIV_W-1:0]  rem_reg [HASH_W];
    logic [HASH_W-1:0] dvd_reg [HASH_W];

    function automatic logic [DIV_W-1:0] step(input logic [DIV_W-1:0] r,
                                              input logic b,
                                              input logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[DIV_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[HASH_W-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= step('0, dividend[HASH_W-1], divisor);
            dvd_reg[0] <= dividend << 1;
        end
    end

    for (genvar s = 1; s < HASH_W; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= step(rem_reg[s-1], dvd_reg[s-1][HASH_W-1], divisor);
                dvd_reg[s] <= dvd_reg[s-1] << 1;
            end
        end
    end

    assign out_vld = vld_reg[HASH_W-1];
    assign rem = rem_reg[HASH_W-1];

    `CBIH_ASSERT_IMP(a_rem_below_divisor, out_vld, rem < divisor, "remainder not below divisor")
    `CBIH_ASSERT_NXT(a_hold_on_stall, !en, $stable(vld_reg), "pipeline moved while stalled")
    `CBIH_ASSERT_IMP(a_dvd_consumed, out_vld, dvd_reg[HASH_W-1] == '0, "dividend bits left over")
endmodule
`default_nettype wire

FILE: design/coupled_bucket_index_hash_unit.sv
// Top level of the coupled bucket index hash unit.
// Takes one item per cycle, unless stalled, and returns its bucket and anchor through
// five stages of MurmurHash3 (one multiply each), 32 stages of restoring
// remainder (one dividend bit each) and the output register where the wrap is
// applied. The whole pipeline halts while a result waits at the output.
// Settings pass through two register steps of clamping before the datapath
// uses them; the remainder stages read them live, so items in flight see a write.
`default_nettype none
`include "coupled_bucket_index_hash_unit_macros.svh"
module coupled_bucket_index_hash_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cbih_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [cbih_pkg::DIV_W-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [cbih_pkg::ROW_W-1:0]  row_index,
    input  wire logic signed [31:0]          key,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cbih_pkg::OUT_W-1:0]       bucket,
    output logic [cbih_pkg::OUT_W-1:0]       anchor
);
    import cbih_pkg::*;

    localparam logic [63:0] LIMIT = 64'd1 << TABLE_BITS;

    logic             mode_reg;
    logic [DIV_W-1:0] table_reg, range_reg;
    logic [DIV_W-2:0] extra_reg;
    logic             mode1_reg;
    logic [DIV_W-1:0] m1_reg, r1_reg;
    logic [DIV_W-2:0] e1_reg;
    logic [DIV_W-1:0] m1_next, r1_next, tmp_m;
    cfg_t cfg_reg, cfg_next;
    logic [DIV_W:0] ar_sum;

    logic en;
    logic h_vld, va, vb;
    logic [HASH_W-1:0] hash_a, hash_b;
    logic [DIV_W-1:0] anchor_w, offset_w;
    logic [DIV_W:0] sum;
    logic out_valid_reg;
    logic [DIV_W-1:0] bucket_reg, anchor_reg, bucket_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CIRCULAR;
            table_reg <= 21'd1024;
            range_reg <= 21'd1024;
            extra_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg <= cfg_wdata[0];
                REG_TABLE: table_reg <= cfg_wdata;
                REG_RANGE: range_reg <= cfg_wdata;
                REG_EXTRA: extra_reg <= cfg_wdata[DIV_W-2:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        tmp_m = (table_reg == '0) ? DIV_W'(1) : table_reg;
        if (64'(tmp_m) > LIMIT)
        begin
            tmp_m = LIMIT[DIV_W-1:0];
        end
        m1_next = tmp_m;
        r1_next = (range_reg == '0) ? DIV_W'(1) : range_reg;
        if (r1_next > tmp_m)
        begin
            r1_next = tmp_m;
        end
        ar_sum = {1'b0, m1_reg - r1_reg} + (DIV_W+1)'(1);
        if (mode1_reg == MODE_CIRCULAR)
        begin
            ar_sum = ar_sum + {2'b0, e1_reg};
            if (ar_sum > {1'b0, m1_reg})
            begin
                ar_sum = {1'b0, m1_reg};
            end
        end
        cfg_next.mode = mode1_reg;
        cfg_next.tsize = m1_reg;
        cfg_next.window = r1_reg;
        cfg_next.arange = ar_sum[DIV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode_reg;
        m1_reg <= m1_next;
        r1_reg <= r1_next;
        e1_reg <= extra_reg;
        cfg_reg <= cfg_next;
    end

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    cbih_hash u_hash (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(in_valid), .word(key), .seed(row_index),
        .out_vld(h_vld), .hash_a(hash_a), .hash_b(hash_b)
    );

    cbih_mod_pipe u_mod_anchor (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(h_vld), .dividend(hash_a), .divisor(cfg_reg.arange),
        .out_vld(va), .rem(anchor_w)
    );

    cbih_mod_pipe u_mod_offset (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(h_vld), .dividend(hash_b), .divisor(cfg_reg.window),
        .out_vld(vb), .rem(offset_w)
    );

    always_comb
    begin
        sum = {1'b0, anchor_w} + {1'b0, offset_w};
        if (cfg_reg.mode == MODE_CIRCULAR && sum >= {1'b0, cfg_reg.tsize})
        begin
            sum = sum - {1'b0, cfg_reg.tsize};
        end
        bucket_next = sum[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= va;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bucket_reg <= bucket_next;
            anchor_reg <= anchor_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign bucket = bucket_reg[OUT_W-1:0];
    assign anchor = anchor_reg[OUT_W-1:0];

    `CBIH_ASSERT_IMP(a_lanes_aligned, 1'b1, va == vb, "remainder lanes out of step")
    `CBIH_ASSERT_IMP(a_circ_bucket, out_valid_reg && cfg_reg.mode == MODE_CIRCULAR,
        bucket_reg < cfg_reg.tsize, "circular bucket beyond table")
    `CBIH_ASSERT_IMP(a_anchor_range, out_valid_reg, anchor_reg < cfg_reg.arange,
        "anchor beyond anchor range")
    `CBIH_ASSERT_IMP(a_naive_bucket, out_valid_reg && cfg_reg.mode == MODE_NAIVE,
        bucket_reg >= anchor_reg, "naive bucket below anchor")
endmodule
`default_nettype wire
